// ===== rtl/core/kot_pkg.sv =====
// ----------------------------------------------------------------------------
// kot_pkg
// Shared types and codes of the keyword and operator tokenizer.
// ----------------------------------------------------------------------------
package kot_pkg;

    localparam int DEF_OFFSET_BITS = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [4:0] K_PLX      = 5'd0;
    localparam logic [4:0] K_IF       = 5'd1;
    localparam logic [4:0] K_ELSE     = 5'd2;
    localparam logic [4:0] K_WHILE    = 5'd3;
    localparam logic [4:0] K_FOR      = 5'd4;
    localparam logic [4:0] K_IDENT    = 5'd5;
    localparam logic [4:0] K_NUMBER   = 5'd6;
    localparam logic [4:0] K_INC      = 5'd7;
    localparam logic [4:0] K_EQEQ     = 5'd8;
    localparam logic [4:0] K_GE       = 5'd9;
    localparam logic [4:0] K_LE       = 5'd10;
    localparam logic [4:0] K_DEC      = 5'd11;
    localparam logic [4:0] K_NE       = 5'd12;
    localparam logic [4:0] K_ADD_EQ   = 5'd13;
    localparam logic [4:0] K_SUB_EQ   = 5'd14;
    localparam logic [4:0] K_SEMI     = 5'd15;
    localparam logic [4:0] K_GT       = 5'd16;
    localparam logic [4:0] K_LT       = 5'd17;
    localparam logic [4:0] K_LPAREN   = 5'd18;
    localparam logic [4:0] K_LBRACE   = 5'd19;
    localparam logic [4:0] K_RPAREN   = 5'd20;
    localparam logic [4:0] K_RBRACE   = 5'd21;
    localparam logic [4:0] K_ASSIGN   = 5'd22;
    localparam logic [4:0] K_PLUS     = 5'd23;
    localparam logic [4:0] K_MINUS    = 5'd24;
    localparam logic [4:0] K_PERCENT  = 5'd25;
    localparam logic [4:0] K_STAR     = 5'd26;
    localparam logic [4:0] K_SLASH    = 5'd27;
    localparam logic [4:0] K_END      = 5'd28;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Keyword spellings, packed most significant byte first
    localparam logic [39:0] KW_PLX   = 40'h00_0070_6C78;
    localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;
    localparam logic [39:0] KW_FOR   = 40'h00_0066_6F72;

    localparam int SLOTS = 4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Tokens raised by one input item, in output order; mask marks the live slots.
    typedef struct packed {
        token_t [SLOTS-1:0] slot;
        logic   [SLOTS-1:0] mask;
    } bundle_t;

    typedef struct packed {
        logic    en;
        bundle_t bundle;
    } push_t;

endpackage

// ===== rtl/core/kot_front.sv =====
// ----------------------------------------------------------------------------
// kot_front
// Takes one byte per cycle while the queue has room, tracks the pending lexeme
// and collects the tokens that the byte closes into one bundle for the queue.
// ----------------------------------------------------------------------------
module kot_front
    import kot_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    input  logic        room,
    output push_t       push
);

    typedef enum logic [8:0] {
        P_NONE  = 9'b000000001,
        P_WORD  = 9'b000000010,
        P_NUM   = 9'b000000100,
        P_PLUS  = 9'b000001000,
        P_EQ    = 9'b000010000,
        P_GT    = 9'b000100000,
        P_LT    = 9'b001000000,
        P_MINUS = 9'b010000000,
        P_BANG  = 9'b100000000
    } pend_t;

    pend_t                  pend_reg, pend_next, pend_mid;
    logic [39:0]            prefix_reg, prefix_next, prefix_mid;
    logic [15:0]            len_reg, len_next, len_mid;
    logic [OFFSET_BITS-1:0] start_reg, start_next, start_mid;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [15:0]            pos16, pos_inc16, start16, start_mid16;
    logic                   is_alpha, is_digit, consumed, accept;
    logic [4:0]             pk;
    bundle_t                bundle;

    function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] ext;
        ext = {16'd0, v};
        return ext[15:0];
    endfunction

    function automatic logic [4:0] word_kind(input logic [15:0] len,
                                              input logic [39:0] pre);
        logic [4:0] k;
        k = K_IDENT;
        if (len == 16'd3 && pre == KW_PLX) k = K_PLX;
        else if (len == 16'd2 && pre == KW_IF) k = K_IF;
        else if (len == 16'd4 && pre == KW_ELSE) k = K_ELSE;
        else if (len == 16'd5 && pre == KW_WHILE) k = K_WHILE;
        else if (len == 16'd3 && pre == KW_FOR) k = K_FOR;
        return k;
    endfunction

    // Token left by a pending lexeme that closes as it stands.
    function automatic token_t flush_token(input pend_t pc, input logic [39:0] pre,
                                           input logic [15:0] len,
                                           input logic [15:0] st);
        token_t t;
        t.start  = st;
        t.length = 16'd1;
        t.last   = 1'b0;
        t.kind   = K_IDENT;
        unique case (pc)
            P_WORD:
            begin
                t.kind   = word_kind(len, pre);
                t.length = len;
            end
            P_NUM:
            begin
                t.kind   = K_NUMBER;
                t.length = len;
            end
            P_PLUS:  t.kind = K_PLUS;
            P_EQ:    t.kind = K_ASSIGN;
            P_GT:    t.kind = K_GT;
            P_LT:    t.kind = K_LT;
            P_MINUS: t.kind = K_MINUS;
            default: t.kind = K_IDENT;
        endcase
        return t;
    endfunction

    function automatic logic flush_valid(input pend_t pc);
        return (pc != P_NONE) && (pc != P_BANG);
    endfunction

    // Kind of the two-character operator formed with the held character, 0 if none.
    function automatic logic [4:0] pair_kind(input pend_t pc, input logic [7:0] ch);
        logic [4:0] k;
        k = 5'd0;
        unique case (pc)
            P_PLUS:
            begin
                if (ch == "+") k = K_INC;
                else if (ch == "=") k = K_ADD_EQ;
            end
            P_EQ:    if (ch == "=") k = K_EQEQ;
            P_GT:    if (ch == "=") k = K_GE;
            P_LT:    if (ch == "=") k = K_LE;
            P_MINUS:
            begin
                if (ch == "-") k = K_DEC;
                else if (ch == "=") k = K_SUB_EQ;
            end
            P_BANG:  if (ch == "=") k = K_NE;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    assign is_alpha  = (text_byte >= "a" && text_byte <= "z") ||
                       (text_byte >= "A" && text_byte <= "Z");
    assign is_digit  = (text_byte >= "0" && text_byte <= "9");
    assign pos_inc   = offset_reg + 1'b1;
    assign pos16     = to16(offset_reg);
    assign pos_inc16 = to16(pos_inc);
    assign start16   = to16(start_reg);
    assign in_ready  = room;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        bundle     = '0;
        consumed   = 1'b0;
        pend_mid   = pend_reg;
        prefix_mid = prefix_reg;
        len_mid    = len_reg;
        start_mid  = start_reg;
        pk         = pair_kind(pend_reg, text_byte);

        // First, the pending lexeme either grows, pairs, or closes.
        unique case (pend_reg)
            P_NONE:
            begin
                consumed = 1'b0;
            end
            P_WORD, P_NUM:
            begin
                if (is_digit || (is_alpha && pend_reg == P_WORD))
                begin
                    consumed = 1'b1;
                    if (len_reg < 16'd5)
                        prefix_mid = {prefix_reg[31:0], text_byte};
                    if (len_reg != LEN_MAX)
                        len_mid = len_reg + 16'd1;
                end
                else
                begin
                    bundle.slot[0] = flush_token(pend_reg, prefix_reg, len_reg, start16);
                    bundle.mask[0] = 1'b1;
                end
            end
            default:
            begin
                if (pk != 5'd0)
                begin
                    consumed       = 1'b1;
                    pend_mid       = P_NONE;
                    bundle.slot[0] = '{kind: pk, start: start16, length: 16'd2,
                                       last: 1'b0};
                    bundle.mask[0] = 1'b1;
                end
                else
                begin
                    bundle.slot[0] = flush_token(pend_reg, prefix_reg, len_reg, start16);
                    bundle.mask[0] = flush_valid(pend_reg);
                end
            end
        endcase

        // A byte not taken by the pending lexeme starts a new one.
        if (!consumed)
        begin
            pend_mid   = P_NONE;
            start_mid  = offset_reg;
            prefix_mid = '0;
            len_mid    = '0;
            bundle.slot[1] = '{kind: K_IDENT, start: pos16, length: 16'd1, last: 1'b0};
            if (is_alpha || is_digit)
            begin
                if (is_alpha)
                    pend_mid = P_WORD;
                else
                    pend_mid = P_NUM;
                prefix_mid = {32'd0, text_byte};
                len_mid    = 16'd1;
            end
            else
            begin
                unique case (text_byte)
                    "+": pend_mid = P_PLUS;
                    "=": pend_mid = P_EQ;
                    ">": pend_mid = P_GT;
                    "<": pend_mid = P_LT;
                    "-": pend_mid = P_MINUS;
                    "!": pend_mid = P_BANG;
                    ";":
                    begin
                        bundle.slot[1].kind = K_SEMI;
                        bundle.mask[1]      = 1'b1;
                    end
                    "(":
                    begin
                        bundle.slot[1].kind = K_LPAREN;
                        bundle.mask[1]      = 1'b1;
                    end
                    "{":
                    begin
                        bundle.slot[1].kind = K_LBRACE;
                        bundle.mask[1]      = 1'b1;
                    end
                    ")":
                    begin
                        bundle.slot[1].kind = K_RPAREN;
                        bundle.mask[1]      = 1'b1;
                    end
                    "}":
                    begin
                        bundle.slot[1].kind = K_RBRACE;
                        bundle.mask[1]      = 1'b1;
                    end
                    "%":
                    begin
                        bundle.slot[1].kind = K_PERCENT;
                        bundle.mask[1]      = 1'b1;
                    end
                    "*":
                    begin
                        bundle.slot[1].kind = K_STAR;
                        bundle.mask[1]      = 1'b1;
                    end
                    "/":
                    begin
                        bundle.slot[1].kind = K_SLASH;
                        bundle.mask[1]      = 1'b1;
                    end
                    default: pend_mid = P_NONE;
                endcase
            end
        end

        start_mid16 = to16(start_mid);

        // On the final byte, close whatever is still held and add the end token.
        bundle.slot[3] = '{kind: K_END, start: pos_inc16, length: 16'd0, last: 1'b1};
        bundle.slot[2] = flush_token(pend_mid, prefix_mid, len_mid, start_mid16);
        if (final_byte)
        begin
            bundle.mask[2] = flush_valid(pend_mid);
            bundle.mask[3] = 1'b1;
            pend_next      = P_NONE;
            prefix_next    = '0;
            len_next       = '0;
            start_next     = '0;
            offset_next    = '0;
        end
        else
        begin
            pend_next      = pend_mid;
            prefix_next    = prefix_mid;
            len_next       = len_mid;
            start_next     = start_mid;
            offset_next    = pos_inc;
        end
    end

    assign push.en     = accept && (bundle.mask != '0);
    assign push.bundle = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= P_NONE;
            prefix_reg <= '0;
            len_reg    <= '0;
            start_reg  <= '0;
            offset_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg   <= pend_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
        end
    end

    // After the last byte of a text, the next one starts a fresh text at offset zero.
    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (offset_reg == '0 && pend_reg == P_NONE))
        else $error("tokenizer state not cleared after final byte");

endmodule

// ===== rtl/core/kot_queue.sv =====
// ----------------------------------------------------------------------------
// kot_queue
// Short queue of token bundles between the front and the back.
// ----------------------------------------------------------------------------
module kot_queue
    import kot_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bundle_t            store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign room       = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push.en && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push.en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
            store_reg[wr_ptr_reg] <= push.bundle;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.en |-> (count_reg != CNT_FULL || pop))
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("bundle popped from an empty queue");

    a_live_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        push.en |-> (push.bundle.mask != '0))
        else $error("empty bundle entered the queue");

endmodule

// ===== rtl/core/kot_back.sv =====
// ----------------------------------------------------------------------------
// kot_back
// Walks the live slots of the head bundle and hands out one token per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module kot_back
    import kot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  bundle_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_text
);

    logic [SLOTS-1:0] sent_reg, sent_next;
    logic             out_valid_reg, out_valid_next;
    token_t           tok_reg;
    logic [SLOTS-1:0] remaining, pick;
    logic [1:0]       idx;
    logic             load;

    assign remaining = head.mask & ~sent_reg;
    assign load      = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        idx  = 2'd0;
        pick = '0;
        priority if (remaining[0])
        begin
            idx  = 2'd0;
            pick = 4'b0001;
        end
        else if (remaining[1])
        begin
            idx  = 2'd1;
            pick = 4'b0010;
        end
        else if (remaining[2])
        begin
            idx  = 2'd2;
            pick = 4'b0100;
        end
        else
        begin
            idx  = 2'd3;
            pick = 4'b1000;
        end
    end

    // The bundle leaves the queue together with its last live token.
    assign pop = load && ((remaining & ~pick) == '0);

    always_comb
    begin
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sent_next      = pop ? '0 : (sent_reg | pick);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            tok_reg <= head.slot[idx];
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = tok_reg.kind;
    assign token_start  = tok_reg.start;
    assign token_length = tok_reg.length;
    assign last_of_text = tok_reg.last;

    a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (remaining != '0))
        else $error("token taken from a slot that is not live");

endmodule

// ===== rtl/core/keyword_operator_tokenizer.sv =====
// ----------------------------------------------------------------------------
// keyword_operator_tokenizer
// The first token of an item is written into the bundle queue and then into the output register.
// One byte is taken per cycle while the bundle queue has room; the output stage sends one token
// per cycle while out_ready allows, so a byte that closes more than one token holds the back until each is sent.
// Reset clears the lexeme state, the text offset, the queue and the output stage.
// ----------------------------------------------------------------------------
module keyword_operator_tokenizer
    import kot_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_text
);

    push_t   push;
    logic    room;
    logic    pop;
    logic    head_valid;
    bundle_t head;

    kot_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .room       (room),
        .push       (push)
    );

    kot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    kot_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_text (last_of_text)
    );

endmodule
